// File: rtl/dpm_pkg.sv
// Package for the dot-product MAC engine: field widths, command bits,
// register indexes and the structs passed between the engine's modules.
// Used by every module under rtl/.
`timescale 1ns / 1ps

package dpm_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned ADDR_W    = 32;
    localparam int unsigned LEN_W     = 24;
    localparam int unsigned PADDR_W   = 4;
    localparam int unsigned S_TDATA_W = 96;
    localparam int unsigned M_TDATA_W = 136;

    // command word bits
    localparam int unsigned CMD_START_BIT = 0;
    localparam int unsigned CMD_STOP_BIT  = 4;

    // item kinds carried on tuser
    localparam logic ACT_COMMAND = 1'b0;
    localparam logic ACT_STEP    = 1'b1;

    typedef enum logic [1:0] {
        REG_A_BASE = 2'd0,
        REG_B_BASE = 2'd1,
        REG_LENGTH = 2'd2,
        REG_RESULT = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [ADDR_W-1:0] a_base;
        logic [ADDR_W-1:0] b_base;
        logic [LEN_W-1:0]  length;
        logic [ADDR_W-1:0] result_addr;
    } t_cfg;

    // decoded input item, product already formed
    typedef struct packed {
        logic              step;
        logic              start;
        logic              stop;
        logic [DATA_W-1:0] prod;
    } t_item;

    typedef struct packed {
        logic              busy;
        logic [DATA_W-1:0] write_data;
        logic [ADDR_W-1:0] write_addr;
        logic              write_valid;
        logic              irq;
        logic [ADDR_W-1:0] read_addr_b;
        logic [ADDR_W-1:0] read_addr_a;
        logic              read_valid;
    } t_result;

endpackage

// File: rtl/dot_product_mac_engine.sv
// Dot-product multiply-accumulate engine, top level.
// Channels: slave stream in, one result item out per item in; APB config.
// Input item: tuser[0] = action (0 command, 1 step). tdata = command word,
//   element a, element b (lowest bits first).
// A command with bit 0 starts a run (index and sum cleared); bit 4 stops
//   any run and emits the result write; with both set the stop wins.
// A step while running adds a*b (wrapped to 32 bits) and requests the
//   next pair; the item on which the index reaches the length pulses irq.
// The result item passes through the input register, then the result
//   register. Throughput: one item per cycle while the receiver takes
//   results, set by the single add into the accumulator that each item
//   needs.
// Reset (synchronous, active low) clears the run state, the accumulator,
//   the configuration registers and both stage valids.
// When the receiver stalls the result register holds; one more item is
//   still taken into the input register, then tready drops until the
//   result is taken.
// User must write configuration only while no item is in flight; not enforced.
`timescale 1ns / 1ps

module dot_product_mac_engine (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [31:0] command_word, [63:32] elem_a, [95:64] elem_b
    input  logic [dpm_pkg::S_TDATA_W-1:0]  i_s_tdata,
    // [0] action
    input  logic                           i_s_tuser,
    // master stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [0] read_valid, [32:1] read_addr_a, [64:33] read_addr_b, [65] irq_pulse,
    // [66] write_valid, [98:67] write_addr, [130:99] write_data,
    // [131] busy_res, [135:132] zero
    output logic [dpm_pkg::M_TDATA_W-1:0]  o_m_tdata,
    // configuration port
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [dpm_pkg::PADDR_W-1:0]    paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);
    import dpm_pkg::*;

    t_cfg  w_cfg;
    t_item w_item;
    logic  w_item_valid;
    logic  w_core_ready;
    logic  w_adv;

    assign w_adv      = !w_item_valid || w_core_ready;
    assign o_s_tready = w_adv;

    dpm_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    dpm_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_valid (i_s_tvalid),
        .i_tdata (i_s_tdata),
        .i_tuser (i_s_tuser),
        .o_valid (w_item_valid),
        .o_item  (w_item)
    );

    dpm_core u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (w_cfg),
        .i_valid    (w_item_valid),
        .i_item     (w_item),
        .o_ready    (w_core_ready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

`ifndef SYNTH
    // a pair is only requested while a run is live
    a_read_needs_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tdata[0]) |-> o_m_tdata[131])
        else $error("read request without busy");

    // a stop command and a run completion never share one item
    a_irq_not_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tdata[65] && o_m_tdata[66]))
        else $error("irq and result write on the same item");

    // input side only backs up behind a stalled result
    a_stall_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("tready low without output stall");
`endif

endmodule

// File: rtl/dpm_cfg_regs.sv
// APB-style configuration registers of the dot-product MAC engine.
// Depends on dpm_pkg for register indexes and the t_cfg struct.
`timescale 1ns / 1ps

module dpm_cfg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [dpm_pkg::PADDR_W-1:0]  paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output dpm_pkg::t_cfg                o_cfg
);
    import dpm_pkg::*;

    t_cfg     r_cfg;
    t_reg_idx w_idx;
    logic     w_wr;

    assign pready = 1'b1;
    assign w_idx  = t_reg_idx'(paddr[PADDR_W-1:2]);
    assign w_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_A_BASE: r_cfg.a_base      <= pwdata;
                REG_B_BASE: r_cfg.b_base      <= pwdata;
                REG_LENGTH: r_cfg.length      <= pwdata[LEN_W-1:0];
                REG_RESULT: r_cfg.result_addr <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_A_BASE: prdata = r_cfg.a_base;
            REG_B_BASE: prdata = r_cfg.b_base;
            REG_LENGTH: prdata = {{(32-LEN_W){1'b0}}, r_cfg.length};
            REG_RESULT: prdata = r_cfg.result_addr;
            default:    prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule

// File: rtl/dpm_in_stage.sv
// Input register of the dot-product MAC engine: decodes the command bits
// and forms the 32-bit wrapped product. Depends on dpm_pkg.
`timescale 1ns / 1ps

module dpm_in_stage (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_adv,
    input  logic                           i_valid,
    input  logic [dpm_pkg::S_TDATA_W-1:0]  i_tdata,
    input  logic                           i_tuser,
    output logic                           o_valid,
    output dpm_pkg::t_item                 o_item
);
    import dpm_pkg::*;

    logic              r_valid;
    t_item             r_item;
    t_item             n_item;
    logic [DATA_W-1:0] w_cmd;
    logic [DATA_W-1:0] w_a;
    logic [DATA_W-1:0] w_b;

    assign w_cmd = i_tdata[DATA_W-1:0];
    assign w_a   = i_tdata[2*DATA_W-1:DATA_W];
    assign w_b   = i_tdata[3*DATA_W-1:2*DATA_W];

    // low half of the product is the same for signed and unsigned operands
    always_comb begin
        n_item.step  = (i_tuser == ACT_STEP);
        n_item.start = w_cmd[CMD_START_BIT];
        n_item.stop  = w_cmd[CMD_STOP_BIT];
        n_item.prod  = w_a * w_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv && i_valid) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

// File: rtl/dpm_core.sv
// Run state, accumulator and result register of the dot-product MAC engine.
// Depends on dpm_pkg for t_cfg, t_item and t_result.
`timescale 1ns / 1ps

module dpm_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  dpm_pkg::t_cfg                  i_cfg,
    input  logic                           i_valid,
    input  dpm_pkg::t_item                 i_item,
    output logic                           o_ready,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [dpm_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import dpm_pkg::*;

    logic              r_running;
    logic [LEN_W-1:0]  r_index;
    logic [DATA_W-1:0] r_acc;
    logic              r_out_valid;
    t_result           r_out;

    logic              n_running;
    logic [LEN_W-1:0]  n_index;
    logic [DATA_W-1:0] n_acc;
    t_result           n_res;

    logic              w_fire;
    logic              w_in_range;
    logic [LEN_W-1:0]  w_idx_step;

    assign o_ready    = !r_out_valid || i_m_tready;
    assign w_fire     = i_valid && o_ready;
    assign w_in_range = (r_index < i_cfg.length);
    assign w_idx_step = w_in_range ? r_index + LEN_W'(1) : r_index;

    always_comb begin
        n_running = r_running;
        n_index   = r_index;
        n_acc     = r_acc;
        n_res     = '0;
        if (!i_item.step) begin
            if (i_item.stop) begin
                n_running         = 1'b0;
                n_res.write_valid = 1'b1;
                n_res.write_addr  = i_cfg.result_addr;
                n_res.write_data  = r_acc;
            end else if (i_item.start) begin
                n_running = 1'b1;
                n_index   = '0;
                n_acc     = '0;
            end
        end else if (r_running) begin
            if (w_in_range) begin
                n_acc = r_acc + i_item.prod;
            end
            // run completes once the index reaches the length
            if (w_idx_step >= i_cfg.length) begin
                n_running = 1'b0;
                n_index   = '0;
                n_res.irq = 1'b1;
            end else begin
                n_index = w_idx_step;
            end
        end
        if (n_running && (n_index < i_cfg.length)) begin
            n_res.read_valid  = 1'b1;
            n_res.read_addr_a = i_cfg.a_base + {{(ADDR_W-LEN_W-2){1'b0}}, n_index, 2'b00};
            n_res.read_addr_b = i_cfg.b_base + {{(ADDR_W-LEN_W-2){1'b0}}, n_index, 2'b00};
        end
        n_res.busy = n_running;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running   <= 1'b0;
            r_index     <= '0;
            r_acc       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_fire) begin
                r_running <= n_running;
                r_index   <= n_index;
                r_acc     <= n_acc;
            end
            if (o_ready) begin
                r_out_valid <= i_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_out <= n_res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-$bits(t_result)){1'b0}}, r_out};

endmodule

// File: test/dpm_tb_pkg.sv
// Result tracking for the dot-product MAC engine testbench: a class that
// mirrors the engine's run state and configuration and checks result items.
// Depends on dpm_pkg for field widths, command bits and register indexes.
`timescale 1ns / 1ps

package dpm_tb_pkg;

    import dpm_pkg::*;

    localparam int unsigned MAX_REPORTS = 10;

    class dot_product_tracker;

        t_cfg                   cfg;
        logic                   running;
        logic [LEN_W-1:0]       elem_idx;
        logic [DATA_W-1:0]      dot_sum;
        t_result                pending_results[$];
        int unsigned            mismatches;

        function new();
            cfg = '0;
            running = 1'b0;
            elem_idx = '0;
            dot_sum = '0;
            mismatches = 0;
        endfunction

        function void set_reg(t_reg_idx idx, logic [31:0] value);
            case (idx)
                REG_A_BASE: cfg.a_base = value;
                REG_B_BASE: cfg.b_base = value;
                REG_LENGTH: cfg.length = value[LEN_W-1:0];
                REG_RESULT: cfg.result_addr = value;
                default: ;
            endcase
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void flag(string what);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
                $display("mismatch %0d: %s", mismatches, what);
        endfunction

        // work out the result item caused by one accepted input item
        function void note_item(logic act, logic [31:0] cmd,
                                logic [DATA_W-1:0] ea, logic [DATA_W-1:0] eb);
            t_result r;
            r = '0;
            if (act == ACT_COMMAND) begin
                if (cmd[CMD_STOP_BIT]) begin
                    running = 1'b0;
                    r.write_valid = 1'b1;
                    r.write_addr = cfg.result_addr;
                    r.write_data = dot_sum;
                end else if (cmd[CMD_START_BIT]) begin
                    running = 1'b1;
                    elem_idx = '0;
                    dot_sum = '0;
                end
            end else if (running) begin
                // length may have shrunk below the index: complete without adding
                if (elem_idx < cfg.length) begin
                    dot_sum = dot_sum + ea * eb;
                    elem_idx = elem_idx + 1'b1;
                end
                if (elem_idx >= cfg.length) begin
                    running = 1'b0;
                    elem_idx = '0;
                    r.irq = 1'b1;
                end
            end
            if (running && elem_idx < cfg.length) begin
                r.read_valid = 1'b1;
                r.read_addr_a = cfg.a_base + {6'd0, elem_idx, 2'b00};
                r.read_addr_b = cfg.b_base + {6'd0, elem_idx, 2'b00};
            end
            r.busy = running;
            pending_results.push_back(r);
        endfunction

        function string show(t_result r);
            return $sformatf("rv=%0b ra=%h rb=%h irq=%0b wv=%0b wa=%h wd=%h busy=%0b",
                             r.read_valid, r.read_addr_a, r.read_addr_b, r.irq,
                             r.write_valid, r.write_addr, r.write_data, r.busy);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] beat);
            t_result got;
            t_result want;
            string   diff;
            got = t_result'(beat[$bits(t_result)-1:0]);
            if (pending_results.size() == 0) begin
                flag({"result item with none expected: ", show(got)});
                return;
            end
            want = pending_results.pop_front();
            diff = "";
            if (got.read_valid !== want.read_valid) diff = {diff, " read_valid"};
            if (got.read_addr_a !== want.read_addr_a) diff = {diff, " read_addr_a"};
            if (got.read_addr_b !== want.read_addr_b) diff = {diff, " read_addr_b"};
            if (got.irq !== want.irq) diff = {diff, " irq_pulse"};
            if (got.write_valid !== want.write_valid) diff = {diff, " write_valid"};
            if (got.write_addr !== want.write_addr) diff = {diff, " write_addr"};
            if (got.write_data !== want.write_data) diff = {diff, " write_data"};
            if (got.busy !== want.busy) diff = {diff, " busy_res"};
            if (beat[M_TDATA_W-1:$bits(t_result)] !== '0) diff = {diff, " padding"};
            if (diff != "")
                flag($sformatf("fields%s\n  expected %s\n  actual   %s",
                               diff, show(want), show(got)));
        endfunction

    endclass

endpackage

// File: test/tb_top.sv
// Testbench top for the dot-product MAC engine: directed and random runs,
// random stalls on both streams, APB register writes between phases.
// Depends on dpm_pkg and dpm_tb_pkg.
`timescale 1ns / 1ps

module tb_top;

    import dpm_pkg::*;
    import dpm_tb_pkg::*;

    localparam int unsigned N_ITEMS    = 1450;
    localparam int unsigned CALM_ITEMS = 150;
    localparam int unsigned IDLE_LIMIT = 1000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [S_TDATA_W-1:0]  i_s_tdata;
    logic                  i_s_tuser;
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    logic [M_TDATA_W-1:0]  o_m_tdata;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [PADDR_W-1:0]    paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    dot_product_tracker    sb;
    int unsigned           items_sent;
    logic                  calm;
    int unsigned           stall_left;
    int unsigned           idle_cycles;

    dot_product_mac_engine u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // receiver stalls in random bursts
    always @(negedge i_clk) begin
        if (stall_left == 0 && !calm && $urandom_range(0, 11) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left > 0) begin
            stall_left--;
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_result(o_m_tdata);
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)
                || (psel && penable && pready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end
        end
    end

    task automatic send_item(logic act, logic [31:0] cmd,
                             logic [DATA_W-1:0] ea, logic [DATA_W-1:0] eb);
        // steps on an idle engine are ignored and not counted
        if (act == ACT_COMMAND || sb.running)
            items_sent++;
        @(negedge i_clk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            i_s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser <= act;
        i_s_tdata <= {eb, ea, cmd};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_item(act, cmd, ea, eb);
    endtask

    task automatic command(logic [31:0] cmd);
        send_item(ACT_COMMAND, cmd, $urandom, $urandom);
    endtask

    task automatic step(logic [DATA_W-1:0] ea, logic [DATA_W-1:0] eb);
        send_item(ACT_STEP, $urandom, ea, eb);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() > 0) @(posedge i_clk);
    endtask

    task automatic cfg_write(t_reg_idx idx, logic [31:0] value);
        @(negedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= PADDR_W'({idx, 2'b00});
        pwdata <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, value);
        @(negedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic logic [31:0] rand_elem();
        case ($urandom_range(0, 11))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_addr();
        case ($urandom_range(0, 7))
            0: return 32'h0;
            1: return 32'hffff_ffff;
            2: return 32'hffff_fffc;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] rand_length();
        logic [31:0] upper;
        upper = $urandom & 32'hff00_0000;
        case ($urandom_range(0, 9))
            7: return upper;
            8: return upper | 32'h00ff_ffff;
            9: return upper | $urandom_range(13, 40);
            default: return upper | $urandom_range(1, 12);
        endcase
    endfunction

    // start word: bit 0 set, bit 4 clear, the rest random
    function automatic logic [31:0] start_word();
        logic [31:0] w;
        w = $urandom;
        w[CMD_START_BIT] = 1'b1;
        w[CMD_STOP_BIT] = 1'b0;
        return w;
    endfunction

    function automatic logic [31:0] stop_word();
        logic [31:0] w;
        w = $urandom;
        w[CMD_STOP_BIT] = 1'b1;
        return w;
    endfunction

    task automatic random_run();
        int unsigned len;
        int unsigned n;
        int          kind;
        kind = $urandom_range(0, 9);
        len = sb.cfg.length;
        if (kind <= 6) begin
            command(start_word());
            n = (len <= 40) ? len : $urandom_range(1, 20);
            if ($urandom_range(0, 3) == 0)
                n = n + $urandom_range(0, 3) - $urandom_range(0, (n < 3) ? n : 3);
            if (n == 0 && len == 0)
                n = 1;
            repeat (n) step(rand_elem(), rand_elem());
            if ($urandom_range(0, 1) == 0)
                command(stop_word());
        end else if (kind == 7) begin
            // noise: arbitrary command words
            repeat ($urandom_range(1, 4)) command($urandom);
        end else if (kind == 8) begin
            repeat ($urandom_range(1, 6))
                send_item(logic'($urandom_range(0, 1)), $urandom, rand_elem(), rand_elem());
        end else begin
            // broken run: restarted or cut short by a stop
            command(start_word());
            repeat ($urandom_range(0, 3)) step(rand_elem(), rand_elem());
            if ($urandom_range(0, 1) == 0)
                command(start_word());
            repeat ($urandom_range(0, 2)) step(rand_elem(), rand_elem());
            command(stop_word());
        end
    endtask

    initial begin
        sb = new();
        items_sent = 0;
        calm = 1'b0;
        stall_left = 0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = ACT_COMMAND;
        i_m_tready = 1'b1;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed part: address wrap, extremes of the elements, every command form
        cfg_write(REG_A_BASE, 32'hffff_fff8);
        cfg_write(REG_B_BASE, 32'h0000_1000);
        cfg_write(REG_LENGTH, 32'h0000_0003);
        cfg_write(REG_RESULT, 32'hffff_ffff);
        step(32'h1234_5678, 32'h9abc_def0);     // idle step, ignored
        command(32'h0000_0010);                 // stop while idle still writes
        command(32'hffff_ffee);                 // neither bit: no effect
        command(32'h0000_0001);
        step(32'h7fff_ffff, 32'h7fff_ffff);
        step(32'h8000_0000, 32'h8000_0000);
        command(32'h0000_0001);                 // restart mid-run
        step(32'h8000_0000, 32'h7fff_ffff);
        step(32'hffff_ffff, 32'h0000_0001);
        step(32'h0000_0000, 32'h0000_0000);     // completes the run
        command(32'h0000_0011);                 // both bits: stop wins
        command(32'h0000_0001);
        step(32'hffff_ffff, 32'hffff_ffff);
        drain();
        cfg_write(REG_LENGTH, 32'hff00_0000);   // masks to zero length
        command(32'h0000_0001);
        step(32'h0000_0005, 32'h0000_0007);     // zero length: irq at once
        drain();
        cfg_write(REG_LENGTH, 32'h0000_0004);
        cfg_write(REG_RESULT, 32'h0000_0000);
        command(32'h0000_0001);
        step(32'h0000_0003, 32'h0000_0004);
        step(32'hffff_fffe, 32'h0000_0005);
        step(32'h0001_0000, 32'h0001_0000);
        drain();
        cfg_write(REG_LENGTH, 32'h0000_0002);   // shrink below the index
        step(32'h7654_3210, 32'h0123_4567);
        command(32'hffff_ffff);
        drain();
        cfg_write(REG_LENGTH, 32'h00ff_ffff);
        cfg_write(REG_A_BASE, 32'h0000_0000);
        cfg_write(REG_B_BASE, 32'hffff_ffff);
        command(32'h0000_0001);
        step(32'h8000_0000, 32'hffff_ffff);
        command(32'h0000_0010);

        // random part
        while (items_sent < N_ITEMS) begin
            drain();
            if ($urandom_range(0, 1) == 0) cfg_write(REG_A_BASE, rand_addr());
            if ($urandom_range(0, 1) == 0) cfg_write(REG_B_BASE, rand_addr());
            if ($urandom_range(0, 1) == 0) cfg_write(REG_LENGTH, rand_length());
            if ($urandom_range(0, 1) == 0) cfg_write(REG_RESULT, rand_addr());
            repeat ($urandom_range(1, 4)) begin
                if (items_sent >= N_ITEMS - CALM_ITEMS)
                    calm = 1'b1;
                random_run();
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (sb.pending() > 0)
            sb.flag($sformatf("%0d result items never arrived", sb.pending()));
        if (sb.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
